// ===== hdl/rtpc_pkg.sv =====
package rtpc_pkg;

    localparam int COLOR_W = 24;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // beat kinds
    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_LOAD     = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] class_number;
        logic [COLOR_W-1:0] color;
    } match_t;

endpackage

// ===== hdl/rtpc_table.sv =====
module rtpc_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [rtpc_pkg::INDEX_W-1:0]       wr_index,
    input  logic [rtpc_pkg::COLOR_W-1:0]       wr_color,
    input  logic signed [VALUE_BITS-1:0]       wr_low,
    input  logic signed [VALUE_BITS-1:0]       wr_high,
    output logic [rtpc_pkg::COLOR_W-1:0]       colors   [TABLE_DEPTH],
    output logic signed [VALUE_BITS-1:0]       minimums [TABLE_DEPTH],
    output logic signed [VALUE_BITS-1:0]       maximums [TABLE_DEPTH]
);

    logic [rtpc_pkg::COLOR_W-1:0] colors_reg   [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] minimums_reg [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] maximums_reg [TABLE_DEPTH];

    // one row of entries, each with its own write enable; an index past the
    // table matches no row and is dropped
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_entry
        always_ff @(posedge clk)
        begin
            if (wr_en && (int'(wr_index) == i))
            begin
                colors_reg[i]   <= wr_color;
                minimums_reg[i] <= wr_low;
                maximums_reg[i] <= wr_high;
            end
        end

        assign colors[i]   = colors_reg[i];
        assign minimums[i] = minimums_reg[i];
        assign maximums[i] = maximums_reg[i];
    end

endmodule

// ===== hdl/rtpc_match.sv =====
module rtpc_match #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic signed [VALUE_BITS-1:0]       value,
    input  logic [rtpc_pkg::COUNT_W-1:0]       entry_count,
    input  logic [rtpc_pkg::COLOR_W-1:0]       colors   [TABLE_DEPTH],
    input  logic signed [VALUE_BITS-1:0]       minimums [TABLE_DEPTH],
    input  logic signed [VALUE_BITS-1:0]       maximums [TABLE_DEPTH],
    output rtpc_pkg::match_t                   result
);

    logic [TABLE_DEPTH-1:0] active;
    logic [TABLE_DEPTH-1:0] eq_hit;
    logic [TABLE_DEPTH-1:0] rng_hit;
    rtpc_pkg::match_t       eq_pick;
    rtpc_pkg::match_t       rng_pick;

    // one equality test and one range test per entry
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
        assign active[i]  = i < int'(entry_count);
        assign eq_hit[i]  = active[i] && (value == minimums[i]);
        assign rng_hit[i] = active[i] && (value >= minimums[i]) && (value <= maximums[i]);
    end

    // lowest index wins: scan downwards so the last hit written is the lowest
    always_comb
    begin
        eq_pick  = '0;
        rng_pick = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (eq_hit[i])
            begin
                eq_pick.hit          = 1'b1;
                eq_pick.class_number = rtpc_pkg::INDEX_W'(i);
                eq_pick.color        = colors[i];
            end
            if (rng_hit[i])
            begin
                rng_pick.hit          = 1'b1;
                rng_pick.class_number = rtpc_pkg::INDEX_W'(i);
                rng_pick.color        = colors[i];
            end
        end
    end

    // exact match on a minimum beats a range match
    assign result = eq_pick.hit ? eq_pick : rng_pick;

endmodule

// ===== hdl/range_table_pixel_classifier_core.sv =====
// Colour classifier for raster cells: each classify beat compares its signed
// 16.16 cell value against the first entry_count entries of a class table of up
// to TABLE_DEPTH rows (colour, minimum, maximum) and returns one result beat;
// the lowest entry whose minimum equals the value wins, else the lowest entry
// whose closed range holds it, else the result is no-data with matched low and
// colour and class number zero. Load beats write one table row and return
// nothing; a row index past the table is dropped. One beat is taken every
// clock while result beats drain; a stalled result holds back a classify in
// the input stage and every beat behind it. out_valid rises once its beat has
// passed the input register and then the result register; the logic between
// those registers is the single bank of 3*TABLE_DEPTH parallel comparators
// and the priority pick. Loads and classifies stay in order, so
// a classify sees every load taken before it. entry_count sits at byte address
// 0 of the APB port; the user must write it only while the block is idle, as
// the block does not enforce this; rows searched must have been loaded first.
module range_table_pixel_classifier_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtpc_pkg::PADDR_W-1:0]       paddr,
    input  logic [rtpc_pkg::PDATA_W-1:0]       pwdata,
    output logic [rtpc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,

    // input beats
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic signed [VALUE_BITS-1:0]       cell_value,
    input  logic [rtpc_pkg::INDEX_W-1:0]       entry_index,
    input  logic [rtpc_pkg::COLOR_W-1:0]       entry_color,
    input  logic signed [VALUE_BITS-1:0]       entry_low,
    input  logic signed [VALUE_BITS-1:0]       entry_high,

    // result beats
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rtpc_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               matched,
    output logic [rtpc_pkg::INDEX_W-1:0]       class_number
);

    // config register
    logic [rtpc_pkg::COUNT_W-1:0] entry_count_reg;

    // input stage
    logic                          s1_valid_reg;
    logic                          s1_mode_reg;
    logic signed [VALUE_BITS-1:0]  s1_value_reg;
    logic [rtpc_pkg::INDEX_W-1:0]  s1_index_reg;
    logic [rtpc_pkg::COLOR_W-1:0]  s1_color_reg;
    logic signed [VALUE_BITS-1:0]  s1_low_reg;
    logic signed [VALUE_BITS-1:0]  s1_high_reg;

    // result stage
    logic                          out_valid_reg;
    rtpc_pkg::match_t              out_reg;

    logic                          in_take;
    logic                          out_free;
    logic                          s1_go;
    logic                          s1_load;
    logic                          s1_classify;

    logic [rtpc_pkg::COLOR_W-1:0]  tbl_colors   [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0]  tbl_minimums [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0]  tbl_maximums [TABLE_DEPTH];
    rtpc_pkg::match_t              match_result;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rtpc_pkg::REG_ENTRY_COUNT)
                  ? rtpc_pkg::PDATA_W'(entry_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == rtpc_pkg::REG_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata[rtpc_pkg::COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------ handshake
    // loads leave the input stage at once; a classify leaves when the result
    // register is empty or being drained this cycle
    assign out_free    = !out_valid_reg || out_ready;
    assign s1_load     = s1_valid_reg && (s1_mode_reg == rtpc_pkg::MODE_LOAD);
    assign s1_classify = s1_valid_reg && (s1_mode_reg == rtpc_pkg::MODE_CLASSIFY);
    assign s1_go       = s1_load || (s1_classify && out_free);
    assign in_ready    = !s1_valid_reg || s1_go;
    assign in_take     = in_valid && in_ready;

    // ----------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg  <= mode;
            s1_value_reg <= cell_value;
            s1_index_reg <= entry_index;
            s1_color_reg <= entry_color;
            s1_low_reg   <= entry_low;
            s1_high_reg  <= entry_high;
        end
    end

    // ------------------------------------------------------------ class table
    // a load writes at the edge it leaves the input stage, so the classify
    // behind it already sees the new row
    rtpc_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_table (
        .clk      (clk),
        .wr_en    (s1_load),
        .wr_index (s1_index_reg),
        .wr_color (s1_color_reg),
        .wr_low   (s1_low_reg),
        .wr_high  (s1_high_reg),
        .colors   (tbl_colors),
        .minimums (tbl_minimums),
        .maximums (tbl_maximums)
    );

    // ---------------------------------------------------------------- search
    rtpc_match #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_match (
        .value       (s1_value_reg),
        .entry_count (entry_count_reg),
        .colors      (tbl_colors),
        .minimums    (tbl_minimums),
        .maximums    (tbl_maximums),
        .result      (match_result)
    );

    // ---------------------------------------------------------- result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_classify && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_classify && out_free)
        begin
            out_reg <= match_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_color  = out_reg.color;
    assign matched      = out_reg.hit;
    assign class_number = out_reg.class_number;

endmodule

// ===== hdl/rtpc_checker.sv =====
module rtpc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtpc_pkg::PADDR_W-1:0]       paddr,
    input  logic [rtpc_pkg::PDATA_W-1:0]       pwdata,
    input  logic [rtpc_pkg::PDATA_W-1:0]       prdata,
    input  logic                               pready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [rtpc_pkg::COLOR_W-1:0]       pixel_color,
    input  logic                               matched,
    input  logic [rtpc_pkg::INDEX_W-1:0]       class_number
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_color)
            && $stable(matched) && $stable(class_number))
        else $error("result beat changed while stalled");

    // no-data results carry zero colour and class
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> (pixel_color == '0) && (class_number == '0))
        else $error("no-data result with nonzero payload");

    // entry_count reads back what was written
    a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == rtpc_pkg::REG_ENTRY_COUNT))
        ##1 (psel && !pwrite && (paddr[2] == rtpc_pkg::REG_ENTRY_COUNT))
        |-> prdata == rtpc_pkg::PDATA_W'($past(pwdata[rtpc_pkg::COUNT_W-1:0])))
        else $error("entry_count readback mismatch");

    // config port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind range_table_pixel_classifier_core rtpc_checker u_rtpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_color  (pixel_color),
    .matched      (matched),
    .class_number (class_number)
);

// ===== tb/testbench.sv =====
module testbench;

    localparam int TABLE_DEPTH    = 16;
    localparam int VALUE_W        = 32;
    localparam int ITEM_TARGET    = 1850;
    // input register plus result register, with a little margin
    localparam int PIPE_SETTLE    = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_DIRECTED     = 23;

    // register index with nothing behind it
    localparam logic             REG_SPARE = 1'b1;
    localparam rtpc_pkg::match_t NO_DATA   = '0;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_SET_COUNT,
        ROW_SPARE_REG
    } row_kind_t;

    // one line of the directed table; a count row carries its value in arg
    typedef struct packed {
        row_kind_t                      kind;
        logic                           mode;
        logic [VALUE_W-1:0]             arg;
        logic [rtpc_pkg::INDEX_W-1:0]   idx;
        logic [rtpc_pkg::COLOR_W-1:0]   color;
        logic [VALUE_W-1:0]             lo;
        logic [VALUE_W-1:0]             hi;
        logic                           typed;
        rtpc_pkg::match_t               want;
    } stim_row_t;

    logic                               clk;
    logic                               rst_n       = 1'b0;

    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [rtpc_pkg::PADDR_W-1:0]       paddr       = '0;
    logic [rtpc_pkg::PDATA_W-1:0]       pwdata      = '0;
    logic [rtpc_pkg::PDATA_W-1:0]       prdata;
    logic                               pready;

    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic                               mode        = rtpc_pkg::MODE_CLASSIFY;
    logic signed [VALUE_W-1:0]          cell_value  = '0;
    logic [rtpc_pkg::INDEX_W-1:0]       entry_index = '0;
    logic [rtpc_pkg::COLOR_W-1:0]       entry_color = '0;
    logic signed [VALUE_W-1:0]          entry_low   = '0;
    logic signed [VALUE_W-1:0]          entry_high  = '0;

    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [rtpc_pkg::COLOR_W-1:0]       pixel_color;
    logic                               matched;
    logic [rtpc_pkg::INDEX_W-1:0]       class_number;

    // travels with the beat: a hand-typed expectation from the directed table
    logic                               beat_typed  = 1'b0;
    rtpc_pkg::match_t                   beat_want   = NO_DATA;

    // our own copy of the class table and of entry_count
    logic [rtpc_pkg::COLOR_W-1:0]       tbl_color   [TABLE_DEPTH];
    logic signed [VALUE_W-1:0]          tbl_low     [TABLE_DEPTH];
    logic signed [VALUE_W-1:0]          tbl_high    [TABLE_DEPTH];
    bit                                 tbl_written [TABLE_DEPTH];
    logic [rtpc_pkg::COUNT_W-1:0]       count_mirror = '0;

    // one entry per classify beat taken, oldest first
    rtpc_pkg::match_t                   expected_pixels [$];

    int                                 n_errors     = 0;
    int                                 n_results    = 0;
    int                                 n_loads      = 0;
    int                                 n_classifies = 0;
    int                                 n_hits       = 0;
    int                                 n_nodata     = 0;
    int                                 n_sent       = 0;
    int                                 n_phases     = 0;
    int                                 idle_cycles  = 0;
    bit [31:0]                          counts_used  = '0;

    // directed part: empty table, extremes of the value range, a point range at
    // the minimum, exact minimum beating a wider range, the upper edge of a
    // closed range, an empty range matched only by its minimum, the spare
    // register index, and a row rewritten in place
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0000_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h7FFF_FFFF, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h8000_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_LOAD,     32'h0000_0000, 4'd0, 24'hFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_LOAD,     32'h0000_0000, 4'd1, 24'h00_0001,
          32'h0001_0000, 32'h0002_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_LOAD,     32'h0000_0000, 4'd2, 24'h12_3456,
          32'h0003_0000, 32'h0001_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_LOAD,     32'h0000_0000, 4'd3, 24'hAB_CDEF,
          32'h0000_8000, 32'h7FFF_FFFF, 1'b0, NO_DATA},
        '{ROW_SET_COUNT, rtpc_pkg::MODE_CLASSIFY, 32'd1,         4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h8000_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 24'hFF_FFFF}},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h8000_0001, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0001_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1, NO_DATA},
        '{ROW_SET_COUNT, rtpc_pkg::MODE_CLASSIFY, 32'd4,         4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0001_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0002_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0003_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0002_8000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h7FFF_FFFF, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0000_7FFF, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'hFFFF_FFFF, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_SPARE_REG, rtpc_pkg::MODE_CLASSIFY, 32'd0,         4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0001_0000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_LOAD,     32'h0000_0000, 4'd1, 24'h00_FF00,
          32'h0001_0000, 32'h0001_0000, 1'b0, NO_DATA},
        '{ROW_BEAT,      rtpc_pkg::MODE_CLASSIFY, 32'h0001_8000, 4'd0, 24'h00_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, NO_DATA}
    };

    range_table_pixel_classifier_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .cell_value   (cell_value),
        .entry_index  (entry_index),
        .entry_color  (entry_color),
        .entry_low    (entry_low),
        .entry_high   (entry_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_color  (pixel_color),
        .matched      (matched),
        .class_number (class_number)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // exact minimum first, then closed range, lowest entry wins in both passes;
    // a count past the table depth searches the whole table
    function automatic rtpc_pkg::match_t classify_cell(logic signed [VALUE_W-1:0] v);
        rtpc_pkg::match_t r;
        int               n;
        r = NO_DATA;
        n = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
        for (int i = 0; i < n; i++)
        begin
            if (!r.hit && v == tbl_low[i])
            begin
                r = '{1'b1, rtpc_pkg::INDEX_W'(i), tbl_color[i]};
            end
        end
        // an empty range (minimum above maximum) can never pass this one
        for (int i = 0; i < n; i++)
        begin
            if (!r.hit && v >= tbl_low[i] && v <= tbl_high[i])
            begin
                r = '{1'b1, rtpc_pkg::INDEX_W'(i), tbl_color[i]};
            end
        end
        return r;
    endfunction

    // values cluster on whole numbers near zero so that ranges overlap and
    // minimums repeat; the rest are extremes or anything at all
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned p;
        int          whole;
        p     = $urandom_range(0, 99);
        whole = int'($urandom_range(0, 16)) - 8;
        if (p < 20)
            return whole * 65536;
        if (p < 45)
            return whole * 65536 + int'($urandom_range(0, 65535));
        if (p < 60)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h8000_0001;
                default: return 32'h7FFF_FFFE;
            endcase
        end
        return $urandom;
    endfunction

    // present one beat and hold it until taken; valid and ready are looked at
    // on the falling edge, where nothing moves, and the beat is taken at the
    // rising edge that follows
    task automatic send_beat(logic m, logic [VALUE_W-1:0] v,
                             logic [rtpc_pkg::INDEX_W-1:0] slot,
                             logic [rtpc_pkg::COLOR_W-1:0] rgb, logic [VALUE_W-1:0] lo,
                             logic [VALUE_W-1:0] hi, logic typed,
                             rtpc_pkg::match_t want);
        bit took;
        mode        <= m;
        cell_value  <= v;
        entry_index <= slot;
        entry_color <= rgb;
        entry_low   <= lo;
        entry_high  <= hi;
        beat_typed  <= typed;
        beat_want   <= want;
        in_valid    <= 1'b1;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        n_sent++;
    endtask

    // sender gaps: mostly none or short, now and then a long one;
    // a steady stretch never pauses
    task automatic pause_sender(bit steady);
        int unsigned p;
        int unsigned g;
        p = $urandom_range(0, 99);
        if (steady || p < 55)
            g = 0;
        else if (p < 85)
            g = $urandom_range(1, 3);
        else if (p < 97)
            g = $urandom_range(4, 10);
        else
            g = $urandom_range(25, 70);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic apb_write(logic reg_sel, logic [rtpc_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rtpc_pkg::PADDR_W'({reg_sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        // the register takes the value at this edge
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (reg_sel == rtpc_pkg::REG_ENTRY_COUNT)
            count_mirror = data[rtpc_pkg::COUNT_W-1:0];
    endtask

    task automatic check_count_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= rtpc_pkg::PADDR_W'({rtpc_pkg::REG_ENTRY_COUNT, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== rtpc_pkg::PDATA_W'(count_mirror))
            report_mismatch($sformatf("entry_count read back %h, expected %h",
                                      prdata, rtpc_pkg::PDATA_W'(count_mirror)));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only while the block is idle: the sender stops until
    // every classify has answered, then loads still in the pipe get time to
    // land before the write
    task automatic set_register(logic reg_sel, logic [rtpc_pkg::COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
        apb_write(reg_sel, rtpc_pkg::PDATA_W'(value));
        if (reg_sel == rtpc_pkg::REG_ENTRY_COUNT)
            counts_used[value] = 1'b1;
        check_count_readback();
    endtask

    // receiver pacing: runs of ready, mostly short, a few long, split by
    // stalls that are now and then much longer than the rest
    initial
    begin : sink_pacing
        int unsigned p;
        @(posedge clk);
        forever
        begin
            p = $urandom_range(0, 99);
            out_ready <= 1'b1;
            repeat ((p < 15) ? $urandom_range(50, 300) : $urandom_range(1, 12))
                @(posedge clk);
            p = $urandom_range(0, 99);
            out_ready <= 1'b0;
            repeat ((p < 5) ? $urandom_range(20, 80) : $urandom_range(1, 4))
                @(posedge clk);
        end
    end

    // everything that crosses either channel is seen here on the falling edge
    // before the rising edge that takes it: loads update our table, classify
    // beats queue their expected pixel, result beats are checked in order
    always @(negedge clk)
    begin : beat_monitor
        rtpc_pkg::match_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (mode == rtpc_pkg::MODE_LOAD)
                begin
                    // a load aimed past the table would be dropped
                    if (int'(entry_index) < TABLE_DEPTH)
                    begin
                        tbl_color[entry_index]   = entry_color;
                        tbl_low[entry_index]     = entry_low;
                        tbl_high[entry_index]    = entry_high;
                        tbl_written[entry_index] = 1'b1;
                    end
                    n_loads++;
                end
                else
                begin
                    expected_pixels.push_back(beat_typed ? beat_want
                                                         : classify_cell(cell_value));
                    n_classifies++;
                end
            end

            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              n_results));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_color !== want.color)
                        report_mismatch($sformatf("result %0d pixel_color %h, expected %h",
                                                  n_results, pixel_color, want.color));
                    if (matched !== want.hit)
                        report_mismatch($sformatf("result %0d matched %b, expected %b",
                                                  n_results, matched, want.hit));
                    if (class_number !== want.class_number)
                        report_mismatch($sformatf("result %0d class_number %0d, expected %0d",
                                                  n_results, class_number, want.class_number));
                    if (want.hit)
                        n_hits++;
                    else
                        n_nodata++;
                end
            end

            // watchdog: cycles in which neither channel nor the register port moves
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_pixels.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t                    row;
        int                           next_count;
        int                           n_eff;
        int                           prefix;
        int                           phase_len;
        int                           load_pct;
        int                           e;
        int unsigned                  p;
        bit                           steady;
        bit                           found;
        logic [rtpc_pkg::INDEX_W-1:0] slot;
        logic [VALUE_W-1:0]           lo;
        logic [VALUE_W-1:0]           hi;
        logic [VALUE_W-1:0]           v;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // entry_count must come out of reset as zero
        check_count_readback();

        // directed table, walked in order
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            case (row.kind)
                ROW_SET_COUNT: set_register(rtpc_pkg::REG_ENTRY_COUNT,
                                            rtpc_pkg::COUNT_W'(row.arg));
                ROW_SPARE_REG: set_register(REG_SPARE, rtpc_pkg::COUNT_W'(row.arg));
                default:
                begin
                    // fields a beat ignores carry noise
                    if (row.mode == rtpc_pkg::MODE_LOAD)
                        send_beat(rtpc_pkg::MODE_LOAD, $urandom, row.idx, row.color,
                                  row.lo, row.hi, 1'b0, NO_DATA);
                    else
                        send_beat(rtpc_pkg::MODE_CLASSIFY, row.arg,
                                  rtpc_pkg::INDEX_W'($urandom),
                                  rtpc_pkg::COLOR_W'($urandom), $urandom, $urandom,
                                  row.typed, row.want);
                    pause_sender(1'b0);
                end
            endcase
        end

        // random phases: each starts idle with a fresh entry_count, then runs a
        // burst of loads and classify beats aimed at the live table
        while (n_sent < ITEM_TARGET)
        begin
            case (n_phases)
                0:       next_count = 4;    // keep the directed rows while the rest fills
                1:       next_count = 0;
                2:       next_count = TABLE_DEPTH;
                3:       next_count = 31;
                4:       next_count = TABLE_DEPTH + 1;
                5:       next_count = 1;
                default: next_count = $urandom_range(0, 31);
            endcase
            // never search a row that has not been loaded
            prefix = 0;
            while (prefix < TABLE_DEPTH && tbl_written[prefix])
                prefix++;
            if (((next_count > TABLE_DEPTH) ? TABLE_DEPTH : next_count) > prefix)
                next_count = prefix;
            set_register(rtpc_pkg::REG_ENTRY_COUNT, rtpc_pkg::COUNT_W'(next_count));
            n_eff = (next_count > TABLE_DEPTH) ? TABLE_DEPTH : next_count;

            steady    = ($urandom_range(0, 3) == 0);
            load_pct  = (n_phases == 0) ? 60 : int'($urandom_range(5, 35));
            phase_len = $urandom_range(20, 110);

            for (int k = 0; k < phase_len; k++)
            begin
                if ($urandom_range(0, 99) < load_pct)
                begin
                    // fill unloaded rows first, then anywhere
                    slot  = rtpc_pkg::INDEX_W'($urandom);
                    found = 1'b0;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (!found && !tbl_written[i])
                        begin
                            slot  = rtpc_pkg::INDEX_W'(i);
                            found = 1'b1;
                        end
                    end
                    lo = pick_value();
                    p  = $urandom_range(0, 99);
                    if (p < 55)
                        hi = lo + $urandom_range(0, 32'h3_0000);
                    else if (p < 70)
                        hi = lo;
                    else if (p < 80)
                        hi = lo - $urandom_range(1, 32'h2_0000);    // empty range
                    else
                        hi = pick_value();
                    send_beat(rtpc_pkg::MODE_LOAD, $urandom, slot,
                              rtpc_pkg::COLOR_W'($urandom), lo, hi, 1'b0, NO_DATA);
                end
                else
                begin
                    p = $urandom_range(0, 99);
                    if (p < 55 && n_eff > 0)
                    begin
                        // land on or just beside an edge of a live row
                        e = $urandom_range(0, n_eff - 1);
                        case ($urandom_range(0, 6))
                            0:       v = tbl_low[e];
                            1:       v = tbl_low[e] - 1;
                            2:       v = tbl_low[e] + 1;
                            3:       v = tbl_high[e];
                            4:       v = tbl_high[e] + 1;
                            5:       v = tbl_high[e] - 1;
                            default: v = tbl_low[e] + ((tbl_high[e] - tbl_low[e]) >>> 1);
                        endcase
                    end
                    else if (p < 80)
                        v = pick_value();
                    else
                        v = $urandom;
                    send_beat(rtpc_pkg::MODE_CLASSIFY, v, rtpc_pkg::INDEX_W'($urandom),
                              rtpc_pkg::COLOR_W'($urandom), $urandom, $urandom,
                              1'b0, NO_DATA);
                end
                pause_sender(steady);
            end
            n_phases++;
        end

        // drain, then give the pipe time to show any stray beat
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_SETTLE) @(posedge clk);

        $display("run: %0d loads and %0d classify beats over %0d random phases, %0d results",
                 n_loads, n_classifies, n_phases, n_results);
        $display("results: %0d matched a class, %0d no-data; %0d distinct entry_count values",
                 n_hits, n_nodata, $countones(counts_used));
        if (n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
